[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros shared by the sequencer rtl
// all checks sample on aclk and are off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FCSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fcss_pkg.sv]
// ----------------------------------------------------------------------------
// fcss_pkg
// shared constants, codes, types and the sine table of the step sequencer
// ----------------------------------------------------------------------------
package fcss_pkg;

    // sequencer geometry
    localparam int SAMPLE_RATE = 44100;
    localparam int STEPS       = 16;
    localparam int CHANNELS    = 4;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int CH_W        = 2;
    localparam int ADDR_W      = CH_W + STEP_W;
    localparam int NOTE_DEPTH  = CHANNELS * STEPS;

    // field widths
    localparam int FREQ_W   = 12;
    localparam int IDX_W    = 20;
    localparam int SPS_W    = 16;
    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 15;
    localparam int FIELD_STEP_W = 4;

    // phase widths: phase < rate, remainder < 2 * rate
    localparam int PH_W  = $clog2(SAMPLE_RATE + 1);
    localparam int R2_W  = PH_W + 1;
    localparam int MAG_W = (PH_W > 16) ? PH_W : 16;

    // rate constants and reciprocals for division by a constant
    localparam logic [31:0] RATE_C    = 32'(SAMPLE_RATE);
    localparam logic [31:0] RATE2_C   = 32'(2 * SAMPLE_RATE);
    localparam logic [31:0] RATE4_C   = 32'(4 * SAMPLE_RATE);
    localparam logic [31:0] RECIP_R   = 32'((64'd1 << 32) / SAMPLE_RATE);
    localparam logic [31:0] RECIP_2R  = 32'((64'd1 << 32) / (2 * SAMPLE_RATE));

    // request kinds
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_RENDER  = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // channel waveforms
    localparam logic [CH_W-1:0] CH_SINE     = 2'd0;
    localparam logic [CH_W-1:0] CH_SQUARE   = 2'd1;
    localparam logic [CH_W-1:0] CH_TRIANGLE = 2'd2;
    localparam logic [CH_W-1:0] CH_SAW      = 2'd3;

    // one channel lookup into the wave pipeline
    typedef struct packed {
        logic              valid;
        logic [CH_W-1:0]   chan;
        logic [FREQ_W-1:0] freq;
    } wave_req_t;

    // one channel output from the wave pipeline
    typedef struct packed {
        logic                       valid;
        logic [CH_W-1:0]            chan;
        logic signed [SAMPLE_W-1:0] value;
    } wave_rsp_t;

    // quarter-wave sine, 15-bit fraction, sin(k*pi/32)
    function automatic logic [15:0] sine_q(input logic [4:0] idx);
        logic [15:0] val;
        case (idx)
            5'd0:    val = 16'd0;
            5'd1:    val = 16'd3212;
            5'd2:    val = 16'd6393;
            5'd3:    val = 16'd9512;
            5'd4:    val = 16'd12540;
            5'd5:    val = 16'd15447;
            5'd6:    val = 16'd18205;
            5'd7:    val = 16'd20788;
            5'd8:    val = 16'd23170;
            5'd9:    val = 16'd25330;
            5'd10:   val = 16'd27246;
            5'd11:   val = 16'd28899;
            5'd12:   val = 16'd30274;
            5'd13:   val = 16'd31357;
            5'd14:   val = 16'd32138;
            5'd15:   val = 16'd32610;
            5'd16:   val = 16'd32768;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

[design/fcss_note_ram.sv]
// ----------------------------------------------------------------------------
// fcss_note_ram
// note table: one write port, one registered read port, per-entry valid bits
// so that entries never written read as silence
// ----------------------------------------------------------------------------
module fcss_note_ram (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [fcss_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [fcss_pkg::FREQ_W-1:0]  wr_data,
    input  logic [fcss_pkg::ADDR_W-1:0]  rd_addr,
    output logic [fcss_pkg::FREQ_W-1:0]  rd_data
);

    logic [fcss_pkg::FREQ_W-1:0]     mem [fcss_pkg::NOTE_DEPTH];
    logic [fcss_pkg::NOTE_DEPTH-1:0] valid_reg;
    logic [fcss_pkg::FREQ_W-1:0]     rd_word_reg;
    logic                            rd_valid_reg;

    // storage array and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    // written-entry flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

[design/fcss_wave_pipe.sv]
// ----------------------------------------------------------------------------
// fcss_wave_pipe
// ten-stage pipeline: phase, waveform shaping and scaling of one channel
// per request, any channel in any slot
// ----------------------------------------------------------------------------
module fcss_wave_pipe (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [fcss_pkg::AMP_W-1:0]   amp,
    input  logic [fcss_pkg::IDX_W-1:0]   sample_idx,
    input  fcss_pkg::wave_req_t          req,
    output fcss_pkg::wave_rsp_t          rsp
);

    localparam int NSTG = 10;

    typedef struct packed {
        logic [fcss_pkg::CH_W-1:0] ch;
        logic                      z;
    } tag_t;

    // stage valid and tag shift line
    logic [NSTG-1:0] vld_reg;
    tag_t            tag_reg [NSTG];

    // stage payload
    logic [31:0]                 s1_n_reg;
    logic [31:0]                 s2_n_reg;
    logic [31:0]                 s2_q_reg;
    logic [fcss_pkg::R2_W-1:0]   s3_r_reg;
    logic [fcss_pkg::PH_W-1:0]   s4_p_reg;
    logic [fcss_pkg::PH_W-1:0]   s5_p_reg;
    logic [fcss_pkg::MAG_W-1:0]  s5_w_reg;
    logic                        s5_neg_reg;
    logic [fcss_pkg::PH_W-1:0]   s6_p_reg;
    logic [fcss_pkg::MAG_W-1:0]  s6_w_reg;
    logic [31:0]                 s6_mul_reg;
    logic                        s6_neg_reg;
    logic [15:0]                 s7_x_reg;
    logic [31:0]                 s7_m_reg;
    logic                        s7_neg_reg;
    logic [15:0]                 s8_t0_reg;
    logic [15:0]                 s8_dl_reg;
    logic [9:0]                  s8_wt_reg;
    logic                        s8_full_reg;
    logic [31:0]                 s8_prod_reg;
    logic [31:0]                 s8_m_reg;
    logic [15:0]                 s8_q_reg;
    logic                        s8_neg_reg;
    logic [15:0]                 s9_val_reg;
    logic                        s9_neg_reg;
    logic signed [fcss_pkg::SAMPLE_W-1:0] s10_val_reg;

    // stage 2: quotient estimate of the phase product
    logic [63:0] s2_prod;
    assign s2_prod = {32'd0, s1_n_reg} * {32'd0, fcss_pkg::RECIP_R};

    // stage 3: remainder below twice the rate
    logic [31:0] s3_rem;
    assign s3_rem = s2_n_reg - 32'(s2_q_reg * fcss_pkg::RATE_C);

    // stage 5: sine index estimate and triangle, saw, square shaping
    logic [31:0] p32;
    logic [63:0] xe_prod;
    logic [31:0] tq;
    logic [31:0] td;
    logic [31:0] sq;
    logic        tri_neg;
    logic        saw_neg;
    logic        sqr_neg;
    logic [31:0] tri_mag;
    logic [31:0] saw_mag;
    logic [fcss_pkg::MAG_W-1:0] s5_w;
    logic                       s5_neg;

    always_comb begin
        p32     = 32'(s4_p_reg);
        xe_prod = {32'd0, p32} * {32'd0, fcss_pkg::RECIP_R};
        // triangle: fold (4p + R) mod 4R around 2R
        tq = (p32 << 2) + fcss_pkg::RATE_C;
        if (tq >= fcss_pkg::RATE4_C) begin
            tq = tq - fcss_pkg::RATE4_C;
        end
        td      = (tq >= fcss_pkg::RATE2_C) ? tq - fcss_pkg::RATE2_C
                                            : fcss_pkg::RATE2_C - tq;
        tri_neg = td > fcss_pkg::RATE_C;
        tri_mag = tri_neg ? td - fcss_pkg::RATE_C : fcss_pkg::RATE_C - td;
        // saw: (2p + R) mod 2R offset by R
        sq = (p32 << 1) + fcss_pkg::RATE_C;
        if (sq >= fcss_pkg::RATE2_C) begin
            sq = sq - fcss_pkg::RATE2_C;
        end
        saw_neg = sq < fcss_pkg::RATE_C;
        saw_mag = saw_neg ? fcss_pkg::RATE_C - sq : sq - fcss_pkg::RATE_C;
        sqr_neg = !((p32 << 1) < fcss_pkg::RATE_C);
        case (tag_reg[3].ch)
            fcss_pkg::CH_SINE: begin
                s5_w   = fcss_pkg::MAG_W'(xe_prod[47:16]);
                s5_neg = 1'b0;
            end
            fcss_pkg::CH_SQUARE: begin
                s5_w   = '0;
                s5_neg = sqr_neg;
            end
            fcss_pkg::CH_TRIANGLE: begin
                s5_w   = fcss_pkg::MAG_W'(tri_mag);
                s5_neg = tri_neg;
            end
            default: begin
                s5_w   = fcss_pkg::MAG_W'(saw_mag);
                s5_neg = saw_neg;
            end
        endcase
    end

    // stage 6: one shared multiplier, index times rate or amplitude times level
    logic [31:0] s6_opb;
    assign s6_opb = (tag_reg[4].ch == fcss_pkg::CH_SINE) ? fcss_pkg::RATE_C : 32'(amp);

    // stage 7: sine index correction, level quotient estimate
    logic [31:0] s7_rem;
    logic [15:0] s7_x;
    logic [63:0] s7_qprod;
    assign s7_rem   = (32'(s6_p_reg) << 16) - s6_mul_reg;
    assign s7_qprod = {32'd0, s6_mul_reg} * {32'd0, fcss_pkg::RECIP_2R};
    always_comb begin
        if (tag_reg[5].ch == fcss_pkg::CH_SINE) begin
            s7_x = (s7_rem >= fcss_pkg::RATE_C) ? 16'(s6_w_reg) + 16'd1 : 16'(s6_w_reg);
        end else begin
            s7_x = 16'(s7_qprod[63:32]);
        end
    end

    // stage 8: quadrant fold and table lookup
    logic [14:0] s8_v;
    logic [4:0]  s8_i;
    logic [15:0] s8_t0;
    logic [15:0] s8_t1;
    assign s8_v  = s7_x_reg[14] ? 15'd16384 - {1'b0, s7_x_reg[13:0]} : {1'b0, s7_x_reg[13:0]};
    assign s8_i  = {1'b0, s8_v[13:10]};
    assign s8_t0 = fcss_pkg::sine_q(s8_i);
    assign s8_t1 = fcss_pkg::sine_q(s8_i + 5'd1);

    // stage 9: interpolation or quotient correction
    logic [25:0] s9_ip;
    logic [31:0] s9_rem;
    logic [15:0] s9_val;
    assign s9_ip  = 26'(s8_dl_reg) * 26'(s8_wt_reg);
    assign s9_rem = s8_m_reg - s8_prod_reg;
    always_comb begin
        if (tag_reg[7].ch == fcss_pkg::CH_SINE) begin
            s9_val = s8_full_reg ? 16'd32768 : s8_t0_reg + 16'(s9_ip >> 10);
        end else begin
            s9_val = (s9_rem >= fcss_pkg::RATE2_C) ? s8_q_reg + 16'd1 : s8_q_reg;
        end
    end

    // stage 10: amplitude scaling and sign
    logic [31:0] s10_sm;
    logic [13:0] s10_mag;
    assign s10_sm = 32'(s9_val_reg) * 32'(amp);
    always_comb begin
        case (tag_reg[8].ch)
            fcss_pkg::CH_SINE:   s10_mag = s10_sm[29:16];
            fcss_pkg::CH_SQUARE: s10_mag = amp[14:1];
            default:             s10_mag = s9_val_reg[13:0];
        endcase
        if (tag_reg[8].z) begin
            s10_mag = '0;
        end
    end

    // valid shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[NSTG-2:0], req.valid};
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        tag_reg[0] <= '{ch: req.chan, z: (req.freq == '0)};
        for (int k = 1; k < NSTG; k++) begin
            tag_reg[k] <= tag_reg[k-1];
        end
        s1_n_reg    <= 32'(sample_idx) * 32'(req.freq);
        s2_n_reg    <= s1_n_reg;
        s2_q_reg    <= s2_prod[63:32];
        s3_r_reg    <= fcss_pkg::R2_W'(s3_rem);
        s4_p_reg    <= (32'(s3_r_reg) >= fcss_pkg::RATE_C)
                       ? fcss_pkg::PH_W'(32'(s3_r_reg) - fcss_pkg::RATE_C)
                       : fcss_pkg::PH_W'(s3_r_reg);
        s5_p_reg    <= s4_p_reg;
        s5_w_reg    <= s5_w;
        s5_neg_reg  <= s5_neg;
        s6_p_reg    <= s5_p_reg;
        s6_w_reg    <= s5_w_reg;
        s6_mul_reg  <= 32'(32'(s5_w_reg) * s6_opb);
        s6_neg_reg  <= s5_neg_reg;
        s7_x_reg    <= s7_x;
        s7_m_reg    <= s6_mul_reg;
        s7_neg_reg  <= s6_neg_reg;
        s8_t0_reg   <= s8_t0;
        s8_dl_reg   <= s8_t1 - s8_t0;
        s8_wt_reg   <= s8_v[9:0];
        s8_full_reg <= s8_v[14];
        s8_prod_reg <= 32'(32'(s7_x_reg) * fcss_pkg::RATE2_C);
        s8_m_reg    <= s7_m_reg;
        s8_q_reg    <= s7_x_reg;
        s8_neg_reg  <= (tag_reg[6].ch == fcss_pkg::CH_SINE) ? s7_x_reg[15] : s7_neg_reg;
        s9_val_reg  <= s9_val;
        s9_neg_reg  <= s8_neg_reg;
        s10_val_reg <= s9_neg_reg ? fcss_pkg::SAMPLE_W'(15'd0 - {1'b0, s10_mag})
                                  : fcss_pkg::SAMPLE_W'({1'b0, s10_mag});
    end

    assign rsp.valid = vld_reg[NSTG-1];
    assign rsp.chan  = tag_reg[NSTG-1].ch;
    assign rsp.value = s10_val_reg;

endmodule

[design/four_channel_step_sequencer_synth_core.sv]
// write and restart requests return nothing
// a render request runs four note table reads at one per cycle
// (single read port), a ten-stage wave pipeline, then the mix and output load
// its result shows on m_tvalid when the output register loads
// synchronous active-low reset: playback at the start, table silent,
// amplitude 11000, samples per step 2000
// ----------------------------------------------------------------------------
// four_channel_step_sequencer_synth_core
// four-channel step sequencer: note table in memory, one mixed sample per
// render request, last sample of the pattern flagged on m_tlast
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_channel_step_sequencer_synth_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_we,
    input  logic                         cfg_addr,
    input  logic [15:0]                  cfg_wdata,
    // request channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // channel[1:0], step[5:2], frequency[17:6]
    input  logic [1:0]                   s_tuser,   // kind[1:0]
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // sample[14:0]
    output logic                         m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    localparam logic CFG_AMPLITUDE = 1'b0;
    localparam logic CFG_SPS       = 1'b1;

    state_t state_reg, state_next;

    logic [fcss_pkg::AMP_W-1:0]  amp_reg;
    logic [fcss_pkg::SPS_W-1:0]  sps_reg;
    logic [fcss_pkg::IDX_W-1:0]  sample_index_reg;
    logic [fcss_pkg::SPS_W-1:0]  step_cnt_reg;
    logic [fcss_pkg::STEP_W-1:0] cur_step_reg;
    logic [fcss_pkg::IDX_W-1:0]  idx_work_reg;
    logic [fcss_pkg::STEP_W-1:0] step_work_reg;
    logic                        end_work_reg;
    logic [fcss_pkg::CH_W-1:0]   issue_cnt_reg;
    logic [fcss_pkg::CH_W-1:0]   res_cnt_reg;
    logic                        rd_pend_reg;
    logic [fcss_pkg::CH_W-1:0]   rd_chan_reg;
    logic signed [16:0]          acc_reg;
    logic                        out_valid_reg;
    logic [fcss_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                        out_end_reg;

    // request fields
    logic [1:0]                        in_kind;
    logic [fcss_pkg::CH_W-1:0]         in_chan;
    logic [fcss_pkg::FIELD_STEP_W-1:0] in_step;
    logic [fcss_pkg::FREQ_W-1:0]       in_freq;
    assign in_kind = s_tuser;
    assign in_chan = s_tdata[1:0];
    assign in_step = s_tdata[5:2];
    assign in_freq = s_tdata[17:6];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // step bookkeeping for a render
    logic [fcss_pkg::SPS_W-1:0] sps_eff;
    logic                       step_done;
    logic                       pat_end;
    assign sps_eff   = (sps_reg == '0) ? fcss_pkg::SPS_W'(1) : sps_reg;
    assign step_done = ({1'b0, step_cnt_reg} + 17'd1) >= {1'b0, sps_eff};
    assign pat_end   = step_done && (cur_step_reg == fcss_pkg::STEP_W'(fcss_pkg::STEPS - 1));

    // note table access
    logic                        ram_we;
    logic [fcss_pkg::ADDR_W-1:0] ram_waddr;
    logic [fcss_pkg::ADDR_W-1:0] ram_raddr;
    logic [fcss_pkg::FREQ_W-1:0] ram_rdata;
    assign ram_we    = accept && (in_kind == fcss_pkg::KIND_WRITE)
                       && (32'(in_step) < 32'(fcss_pkg::STEPS));
    assign ram_waddr = {in_chan, fcss_pkg::STEP_W'(in_step)};
    assign ram_raddr = {issue_cnt_reg, step_work_reg};

    fcss_note_ram u_note_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (in_freq),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // wave pipeline
    fcss_pkg::wave_req_t pipe_req;
    fcss_pkg::wave_rsp_t pipe_rsp;
    assign pipe_req.valid = rd_pend_reg;
    assign pipe_req.chan  = rd_chan_reg;
    assign pipe_req.freq  = ram_rdata;

    fcss_wave_pipe u_wave_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .amp        (amp_reg),
        .sample_idx (idx_work_reg),
        .req        (pipe_req),
        .rsp        (pipe_rsp)
    );

    // mix: sum of four divided by four, truncated toward zero
    logic        acc_neg;
    logic [16:0] acc_mag;
    logic [14:0] mix_q;
    logic [fcss_pkg::SAMPLE_W-1:0] mix_sample;
    assign acc_neg    = acc_reg[16];
    assign acc_mag    = acc_neg ? 17'(17'd0 - acc_reg) : 17'(acc_reg);
    assign mix_q      = acc_mag[16:2];
    assign mix_sample = acc_neg ? 15'(15'd0 - mix_q) : mix_q;

    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // control sequence
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_kind == fcss_pkg::KIND_RENDER)) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (issue_cnt_reg == fcss_pkg::CH_W'(fcss_pkg::CHANNELS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_rsp.valid
                    && (res_cnt_reg == fcss_pkg::CH_W'(fcss_pkg::CHANNELS - 1))) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers and playback position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            amp_reg          <= fcss_pkg::AMP_W'(11000);
            sps_reg          <= fcss_pkg::SPS_W'(2000);
            sample_index_reg <= '0;
            step_cnt_reg     <= '0;
            cur_step_reg     <= '0;
            issue_cnt_reg    <= '0;
            res_cnt_reg      <= '0;
            rd_pend_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_READ);
            // register writes
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_AMPLITUDE: amp_reg <= cfg_wdata[fcss_pkg::AMP_W-1:0];
                    CFG_SPS:       sps_reg <= cfg_wdata[fcss_pkg::SPS_W-1:0];
                    default:       ;
                endcase
            end
            // playback position moves when a restart or render request is taken
            if (accept && (in_kind == fcss_pkg::KIND_RESTART)) begin
                sample_index_reg <= '0;
                step_cnt_reg     <= '0;
                cur_step_reg     <= '0;
            end else if (accept && (in_kind == fcss_pkg::KIND_RENDER)) begin
                if (pat_end) begin
                    sample_index_reg <= '0;
                    step_cnt_reg     <= '0;
                    cur_step_reg     <= '0;
                end else begin
                    sample_index_reg <= sample_index_reg + fcss_pkg::IDX_W'(1);
                    if (step_done) begin
                        step_cnt_reg <= '0;
                        cur_step_reg <= cur_step_reg + fcss_pkg::STEP_W'(1);
                    end else begin
                        step_cnt_reg <= step_cnt_reg + fcss_pkg::SPS_W'(1);
                    end
                end
            end
            // channel read and result counters
            if (state_reg == ST_READ) begin
                issue_cnt_reg <= issue_cnt_reg + fcss_pkg::CH_W'(1);
            end else begin
                issue_cnt_reg <= '0;
            end
            if (accept) begin
                res_cnt_reg <= '0;
            end else if (pipe_rsp.valid) begin
                res_cnt_reg <= res_cnt_reg + fcss_pkg::CH_W'(1);
            end
            // output register
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // work snapshot, accumulator and output payload
    always_ff @(posedge aclk) begin
        if (accept && (in_kind == fcss_pkg::KIND_RENDER)) begin
            idx_work_reg  <= sample_index_reg;
            step_work_reg <= cur_step_reg;
            end_work_reg  <= pat_end;
        end
        rd_chan_reg <= issue_cnt_reg;
        if (accept) begin
            acc_reg <= '0;
        end else if (pipe_rsp.valid) begin
            acc_reg <= acc_reg + {{2{pipe_rsp.value[14]}}, pipe_rsp.value};
        end
        if (out_load) begin
            out_sample_reg <= mix_sample;
            out_end_reg    <= end_work_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_sample_reg};
    assign m_tlast  = out_end_reg;

    `FCSS_ASSERT_IMP(a_rsp_in_drain, pipe_rsp.valid, state_reg == ST_DRAIN, "channel result outside drain")
    `FCSS_ASSERT_IMP(a_done_after_all, (state_reg == ST_DRAIN) && (state_next == ST_DONE), (res_cnt_reg == fcss_pkg::CH_W'(fcss_pkg::CHANNELS - 1)) && pipe_rsp.valid, "mix finished early")
    `FCSS_ASSERT_NXT(a_render_starts, accept && (in_kind == fcss_pkg::KIND_RENDER), (state_reg == ST_READ) && (acc_reg == '0) && (issue_cnt_reg == '0), "render did not start clean")

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the four-channel step sequencer synthesizer. It fills the note
// table with write requests, restarts playback, and renders samples over
// several amplitude and step-length settings. Both stream sides insert random
// gaps and stalls. A behavioral predictor inside the bench computes each mixed
// sample and its pattern-end flag, and the bench checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcss_pkg::*;

    // register indexes and the kind the block ignores
    localparam logic       REG_AMPLITUDE = 1'b0;
    localparam logic       REG_STEP_LEN  = 1'b1;
    localparam logic [1:0] KIND_IGNORED  = 2'd3;

    // leave margin after the last render before touching registers
    localparam int DRAIN_CYCLES = 24;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                pattern_end;
    } mix_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // channel[1:0], step[5:2], frequency[17:6]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // sample[14:0]
    logic        m_tlast;

    // predictor state
    logic [AMP_W-1:0]  amp_reg  = 15'd11000;
    logic [SPS_W-1:0]  sps_reg  = 16'd2000;
    logic [FREQ_W-1:0] note_mem [NOTE_DEPTH];
    logic [IDX_W-1:0]  play_index = '0;
    logic [SPS_W-1:0]  step_count = '0;
    logic [STEP_W-1:0] play_step  = '0;

    mix_result_t expected_mix [$];
    mix_result_t oldest_mix;
    int          fail_count   = 0;
    int          quiet_cycles = 0;
    bit          idle_on      = 1'b1;
    int          rx_mode_left = 0;
    int          rx_hold      = 0;
    bit          rx_stalls    = 1'b0;

    four_channel_step_sequencer_synth_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // quarter-wave sine points, 15-bit fraction
    function automatic longint quarter_sine(input longint k);
        case (k)
            0:       return 0;
            1:       return 3212;
            2:       return 6393;
            3:       return 9512;
            4:       return 12540;
            5:       return 15447;
            6:       return 18205;
            7:       return 20788;
            8:       return 23170;
            9:       return 25330;
            10:      return 27246;
            11:      return 28899;
            12:      return 30274;
            13:      return 31357;
            14:      return 32138;
            15:      return 32610;
            default: return 32768;
        endcase
    endfunction

    // one channel output at the current sample index
    function automatic longint wave_value(input logic [1:0] chan,
                                          input logic [FREQ_W-1:0] freq);
        longint rate, amp, ph, fr, x, quad, u, v, s, k, w, mag, q, d;
        rate = SAMPLE_RATE;
        amp  = amp_reg;
        fr   = freq;
        ph   = play_index;
        if (freq == 0)
            return 0;
        ph = (ph * fr) % rate;
        case (chan)
            CH_SINE: begin
                x    = (ph << 16) / rate;
                quad = (x >> 14) & 3;
                u    = x & 16383;
                v    = (quad & 1) ? 16384 - u : u;
                if (v >= 16384) begin
                    s = 32768;
                end else begin
                    k = v >> 10;
                    w = v & 1023;
                    s = quarter_sine(k) + (((quarter_sine(k + 1) - quarter_sine(k)) * w) >> 10);
                end
                mag = (s * amp) >> 16;
                return (quad >= 2) ? -mag : mag;
            end
            CH_SQUARE: begin
                return (2 * ph < rate) ? (amp >> 1) : -(amp >> 1);
            end
            CH_TRIANGLE: begin
                q = (4 * ph + rate) % (4 * rate);
                d = q - 2 * rate;
                if (d < 0)
                    d = -d;
                return (amp * (rate - d)) / (2 * rate);
            end
            default: begin
                q = (2 * ph + rate) % (2 * rate);
                return (amp * (q - rate)) / (2 * rate);
            end
        endcase
    endfunction

    // mix four channels at the current step and advance playback
    function automatic mix_result_t mix_next_sample();
        longint      sum;
        longint      mixed;
        int          step_len;
        logic        step_done;
        mix_result_t rec;
        step_len = (sps_reg == 0) ? 1 : int'(sps_reg);
        sum = 0;
        for (int c = 0; c < CHANNELS; c++)
            sum += wave_value(2'(c), note_mem[{2'(c), play_step}]);
        mixed = sum / 4;
        step_done = (int'(step_count) + 1 >= step_len);
        rec.sample = mixed[SAMPLE_W-1:0];
        rec.pattern_end = step_done && (play_step == STEPS - 1);
        if (rec.pattern_end) begin
            play_index = '0;
            step_count = '0;
            play_step  = '0;
        end else begin
            play_index = play_index + 1'b1;
            if (step_done) begin
                step_count = '0;
                play_step  = play_step + 1'b1;
            end else begin
                step_count = step_count + 1'b1;
            end
        end
        return rec;
    endfunction

    // predictor update for one accepted request
    function automatic void apply_request(input logic [1:0] kind, input logic [1:0] chan,
                                          input logic [3:0] note_step,
                                          input logic [FREQ_W-1:0] freq);
        case (kind)
            KIND_WRITE:   note_mem[{chan, note_step}] = freq;
            KIND_RENDER:  expected_mix.push_back(mix_next_sample());
            KIND_RESTART: begin
                play_index = '0;
                step_count = '0;
                play_step  = '0;
            end
            default: ;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r == 2)
            return FREQ_W'($urandom_range(1, 15));
        return FREQ_W'($urandom);
    endfunction

    // send one request, valid stays high after acceptance
    task automatic send_request(input logic [1:0] kind, input logic [1:0] chan,
                                input logic [3:0] note_step, input logic [FREQ_W-1:0] freq);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, freq, note_step, chan};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_request(kind, chan, note_step, freq);
    endtask

    task automatic render(input int count);
        repeat (count) send_request(KIND_RENDER, '0, '0, '0);
    endtask

    // wait for all results and let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_mix.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // idle the block, then write both registers
    task automatic program_regs(input logic [AMP_W-1:0] amp, input logic [15:0] step_len);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_AMPLITUDE;
        cfg_wdata <= {1'b0, amp};
        @(posedge aclk);
        amp_reg = amp;
        cfg_addr  <= REG_STEP_LEN;
        cfg_wdata <= step_len;
        @(posedge aclk);
        sps_reg = step_len;
        cfg_we <= 1'b0;
    endtask

    // ignored kind with every field bit set, then silence from an empty table
    task automatic test_silent_table();
        send_request(KIND_IGNORED, '1, '1, '1);
        render(1);
    endtask

    // frequency and step extremes on every waveform
    task automatic test_note_extremes();
        send_request(KIND_WRITE, CH_SINE, 4'd0, 12'd4095);
        send_request(KIND_WRITE, CH_SQUARE, 4'd0, 12'd1);
        send_request(KIND_WRITE, CH_TRIANGLE, 4'd0, 12'd2048);
        send_request(KIND_WRITE, CH_SAW, 4'd15, 12'd4095);
        render(2);
    endtask

    // zero step length behaves as one: pattern ends on the 16th sample and wraps
    task automatic test_pattern_wrap();
        program_regs(15'd32767, 16'd0);
        send_request(KIND_RESTART, '0, '0, '0);
        render(17);
    endtask

    // step length cut below the current count ends the step at once
    task automatic test_step_shrink();
        program_regs(15'd20000, 16'd5);
        send_request(KIND_RESTART, '0, '0, '0);
        render(4);
        program_regs(15'd20000, 16'd2);
        render(2);
    endtask

    task automatic test_load_table();
        for (int ch = 0; ch < CHANNELS; ch++)
            for (int st = 0; st < STEPS; st++)
                send_request(KIND_WRITE, 2'(ch), 4'(st), pick_freq());
    endtask

    // mostly renders with note edits, some restarts and ignored requests
    task automatic play_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 25)
                send_request(KIND_WRITE, 2'($urandom), 4'($urandom), pick_freq());
            else if (r < 90)
                render(1);
            else if (r < 94)
                send_request(KIND_RESTART, 2'($urandom), 4'($urandom), 12'($urandom));
            else
                send_request(KIND_IGNORED, 2'($urandom), 4'($urandom), 12'($urandom));
        end
    endtask

    // random play across register settings, extremes included
    task automatic test_random_phases();
        idle_on = 1'b1;
        program_regs(15'd32767, 16'd1);
        play_random(170);
        idle_on = 1'b0;
        program_regs(15'd0, 16'd3);
        play_random(150);
        idle_on = 1'b1;
        program_regs(15'($urandom), 16'd0);
        play_random(170);
        program_regs(15'($urandom), 16'($urandom_range(1, 8)));
        play_random(170);
        idle_on = ($urandom_range(1) != 0);
        program_regs(15'd32767, 16'd65535);
        play_random(130);
        idle_on = 1'b1;
        program_regs(15'($urandom), 16'd2);
        play_random(150);
    endtask

    // result side: stretches without stalls and stretches with random stalls
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_stalls    = ($urandom_range(3) != 0);
            rx_mode_left = $urandom_range(100, 400);
        end
        rx_mode_left--;
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_stalls && $urandom_range(3) == 0) begin
            rx_hold = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result with the oldest expected sample
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_mix.size() == 0) begin
                $error("unexpected result: sample %0d, pattern_end %0b",
                       $signed(m_tdata[SAMPLE_W-1:0]), m_tlast);
                fail_count++;
            end else begin
                oldest_mix = expected_mix.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== oldest_mix.sample) begin
                    $error("sample: expected %0d, got %0d", $signed(oldest_mix.sample),
                           $signed(m_tdata[SAMPLE_W-1:0]));
                    fail_count++;
                end
                if (m_tlast !== oldest_mix.pattern_end) begin
                    $error("pattern_end: expected %0b, got %0b", oldest_mix.pattern_end,
                           m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_AMPLITUDE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_WRITE;
        for (int i = 0; i < NOTE_DEPTH; i++)
            note_mem[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_silent_table();
        test_note_extremes();
        test_pattern_wrap();
        test_step_shrink();
        test_load_table();
        test_random_phases();
        drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/fcss_pkg.sv
design/fcss_note_ram.sv
design/fcss_wave_pipe.sv
design/four_channel_step_sequencer_synth_core.sv
verif/tb_top.sv
